/* hw/rtl/llpq_pkg.sv */
// shared types, codes and the priority relation for the linked list priority queue
package llpq_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int DATA_W       = 32;
  localparam int COUNT_W      = 5;

  typedef logic signed [DATA_W-1:0] word_t;

  typedef enum logic [1:0] {
    FN_PUSH   = 2'd0,
    FN_POP    = 2'd1,
    FN_PEEK   = 2'd2,
    FN_LOOKUP = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    REL_LT = 2'd0,
    REL_LE = 2'd1,
    REL_GT = 2'd2,
    REL_GE = 2'd3
  } rel_t;

  // node store access command: read, node write, link write
  typedef struct packed {
    logic rd_en;
    logic wr_node;
    logic wr_link;
  } store_cmd_t;

  typedef struct packed {
    word_t                element;
    word_t                prio;
    status_t              status;
    logic                 is_empty;
    logic [COUNT_W-1:0]   count;
  } result_t;

  // true when candidate a should replace current best b
  function automatic logic rel_holds(rel_t mode, word_t a, word_t b);
    logic r;
    case (mode)
      REL_LT:  r = (a < b);
      REL_LE:  r = (a <= b);
      REL_GT:  r = (a > b);
      REL_GE:  r = (a >= b);
      default: r = (a >= b);
    endcase
    return r;
  endfunction

endpackage

/* hw/rtl/llpq_store.sv */
// node store: element, priority and link memories with a fill mark for the free chain
module llpq_store #(
  parameter int  CAPACITY = llpq_pkg::CAPACITY_DEF,
  localparam int IW       = $clog2(CAPACITY + 1),
  localparam int AW       = $clog2(CAPACITY)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  llpq_pkg::store_cmd_t cmd,
  input  logic [IW-1:0]        rd_addr,
  input  logic [IW-1:0]        wr_addr,
  input  llpq_pkg::word_t      wr_elem,
  input  llpq_pkg::word_t      wr_prio,
  input  logic [IW-1:0]        wr_link,
  output logic [IW-1:0]        rd_idx,
  output llpq_pkg::word_t      rd_elem,
  output llpq_pkg::word_t      rd_prio,
  output logic [IW-1:0]        rd_link
);

  llpq_pkg::word_t elem_mem [CAPACITY];
  llpq_pkg::word_t prio_mem [CAPACITY];
  logic [IW-1:0]   link_mem [CAPACITY];

  // nodes at or above the fill mark were never linked: their link is index + 1
  logic [IW-1:0]   fill;
  logic            unwritten;
  logic [IW-1:0]   link_q;

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_elem   <= elem_mem[rd_addr[AW-1:0]];
      rd_prio   <= prio_mem[rd_addr[AW-1:0]];
      link_q    <= link_mem[rd_addr[AW-1:0]];
      rd_idx    <= rd_addr;
      unwritten <= (rd_addr >= fill);
    end
    if (cmd.wr_node) begin
      elem_mem[wr_addr[AW-1:0]] <= wr_elem;
      prio_mem[wr_addr[AW-1:0]] <= wr_prio;
    end
    if (cmd.wr_link) begin
      link_mem[wr_addr[AW-1:0]] <= wr_link;
    end
  end

  // only allocation writes a link at the fill mark
  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (cmd.wr_link && (wr_addr == fill)) begin
      fill <= fill + 1'b1;
    end
  end

  assign rd_link = unwritten ? (rd_idx + 1'b1) : link_q;

endmodule

/* hw/rtl/llpq_ctrl.sv */
// sequencer: list walks, free list handling and result formation
module llpq_ctrl #(
  parameter int  CAPACITY = llpq_pkg::CAPACITY_DEF,
  localparam int IW       = $clog2(CAPACITY + 1)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [1:0]           rel_mode,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           func,
  input  llpq_pkg::word_t      element,
  input  llpq_pkg::word_t      priority_req,
  output llpq_pkg::store_cmd_t cmd,
  output logic [IW-1:0]        rd_addr,
  output logic [IW-1:0]        wr_addr,
  output llpq_pkg::word_t      wr_elem,
  output llpq_pkg::word_t      wr_prio,
  output logic [IW-1:0]        wr_link,
  input  logic [IW-1:0]        rd_idx,
  input  llpq_pkg::word_t      rd_elem,
  input  llpq_pkg::word_t      rd_prio,
  input  logic [IW-1:0]        rd_link,
  output logic                 res_valid,
  input  logic                 res_ready,
  output llpq_pkg::result_t    res
);

  localparam logic [IW-1:0] NIL       = IW'(CAPACITY);
  localparam logic [IW-1:0] LAST_STEP = IW'(CAPACITY - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PUSH_WR,
    S_PUSH_LINK,
    S_SCAN,
    S_SCAN2,
    S_UNLINK_PREV,
    S_UNLINK_FREE,
    S_DONE
  } state_t;

  state_t              state;
  llpq_pkg::func_t     op;
  llpq_pkg::func_t     in_func;
  llpq_pkg::word_t     key_elem;
  llpq_pkg::word_t     key_prio;
  llpq_pkg::word_t     best_elem;
  llpq_pkg::word_t     best_prio;
  llpq_pkg::word_t     res_elem;
  llpq_pkg::word_t     res_prio;
  llpq_pkg::status_t   res_status;
  logic [IW-1:0]       list_head;
  logic [IW-1:0]       list_tail;
  logic [IW-1:0]       free_head;
  logic [IW-1:0]       cnt;
  logic [IW-1:0]       steps;
  logic [IW-1:0]       prev;
  logic [IW-1:0]       cur;
  logic [IW-1:0]       cur_link;

  logic                accept;
  logic                is_full;
  logic                head_nil;
  logic                list_empty;
  logic                link_ok;
  logic                take_best;
  logic                hit_lookup;
  logic                hit_pop;
  llpq_pkg::word_t     new_best_elem;
  llpq_pkg::word_t     new_best_prio;
  logic [31:0]         cnt_w;

  assign in_ready   = (state == S_IDLE);
  assign accept     = in_valid && in_ready;
  assign in_func    = llpq_pkg::func_t'(func);
  assign is_full    = (cnt >= NIL) || (free_head >= NIL);
  assign head_nil   = (list_head >= NIL);
  assign list_empty = (cnt == '0) || head_nil;
  assign link_ok    = (rd_link < NIL) && (steps < LAST_STEP);
  assign hit_lookup = (rd_elem == key_elem);
  assign hit_pop    = (rd_elem == res_elem) && (rd_prio == res_prio);
  // first node of a walk always becomes the best so far
  assign take_best  = (steps == '0) ||
                      llpq_pkg::rel_holds(llpq_pkg::rel_t'(rel_mode), rd_prio, best_prio);
  assign new_best_elem = take_best ? rd_elem : best_elem;
  assign new_best_prio = take_best ? rd_prio : best_prio;

  // node store accesses
  always_comb begin
    cmd     = '0;
    rd_addr = list_head;
    wr_addr = cur;
    wr_link = NIL;
    wr_elem = key_elem;
    wr_prio = key_prio;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (in_func)
            llpq_pkg::FN_PUSH: begin
              cmd.rd_en = !is_full;
              rd_addr   = free_head;
            end
            llpq_pkg::FN_POP, llpq_pkg::FN_PEEK: begin
              cmd.rd_en = !list_empty;
            end
            llpq_pkg::FN_LOOKUP: begin
              cmd.rd_en = !head_nil;
            end
            default: begin
              cmd.rd_en = 1'b0;
            end
          endcase
        end
      end
      S_PUSH_WR: begin
        cmd.wr_node = 1'b1;
        cmd.wr_link = 1'b1;
        wr_addr     = rd_idx;
        wr_link     = NIL;
      end
      S_PUSH_LINK: begin
        cmd.wr_link = 1'b1;
        wr_addr     = list_tail;
        wr_link     = cur;
      end
      S_SCAN: begin
        if (op == llpq_pkg::FN_LOOKUP) begin
          cmd.rd_en = !hit_lookup && link_ok;
          rd_addr   = rd_link;
        end else if (link_ok) begin
          cmd.rd_en = 1'b1;
          rd_addr   = rd_link;
        end else begin
          // second walk for pop starts at the head
          cmd.rd_en = (op == llpq_pkg::FN_POP);
          rd_addr   = list_head;
        end
      end
      S_SCAN2: begin
        cmd.rd_en = !hit_pop && link_ok;
        rd_addr   = rd_link;
      end
      S_UNLINK_PREV: begin
        cmd.wr_link = 1'b1;
        wr_addr     = prev;
        wr_link     = cur_link;
      end
      S_UNLINK_FREE: begin
        cmd.wr_link = 1'b1;
        wr_addr     = cur;
        wr_link     = free_head;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      list_head <= NIL;
      list_tail <= NIL;
      free_head <= '0;
      cnt       <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            op         <= in_func;
            key_elem   <= element;
            key_prio   <= priority_req;
            res_elem   <= '0;
            res_prio   <= '0;
            res_status <= llpq_pkg::ST_OK;
            steps      <= '0;
            prev       <= NIL;
            case (in_func)
              llpq_pkg::FN_PUSH: begin
                if (is_full) begin
                  res_status <= llpq_pkg::ST_FULL;
                  state      <= S_DONE;
                end else begin
                  state <= S_PUSH_WR;
                end
              end
              llpq_pkg::FN_POP, llpq_pkg::FN_PEEK: begin
                if (list_empty) begin
                  res_status <= llpq_pkg::ST_EMPTY;
                  state      <= S_DONE;
                end else begin
                  state <= S_SCAN;
                end
              end
              llpq_pkg::FN_LOOKUP: begin
                if (head_nil) begin
                  res_prio   <= '1;
                  res_status <= llpq_pkg::ST_NOT_FOUND;
                  state      <= S_DONE;
                end else begin
                  state <= S_SCAN;
                end
              end
              default: begin
                state <= S_DONE;
              end
            endcase
          end
        end
        S_PUSH_WR: begin
          free_head <= rd_link;
          cur       <= rd_idx;
          cnt       <= cnt + 1'b1;
          if (head_nil) begin
            list_head <= rd_idx;
            list_tail <= rd_idx;
            state     <= S_DONE;
          end else begin
            state <= S_PUSH_LINK;
          end
        end
        S_PUSH_LINK: begin
          list_tail <= cur;
          state     <= S_DONE;
        end
        S_SCAN: begin
          if (op == llpq_pkg::FN_LOOKUP) begin
            if (hit_lookup) begin
              res_prio <= rd_prio;
              state    <= S_DONE;
            end else if (link_ok) begin
              steps <= steps + 1'b1;
            end else begin
              res_prio   <= '1;
              res_status <= llpq_pkg::ST_NOT_FOUND;
              state      <= S_DONE;
            end
          end else begin
            best_elem <= new_best_elem;
            best_prio <= new_best_prio;
            if (link_ok) begin
              steps <= steps + 1'b1;
            end else begin
              res_elem <= new_best_elem;
              res_prio <= new_best_prio;
              steps    <= '0;
              prev     <= NIL;
              state    <= (op == llpq_pkg::FN_POP) ? S_SCAN2 : S_DONE;
            end
          end
        end
        S_SCAN2: begin
          // unlink the first node equal to the reported pair
          if (hit_pop) begin
            cur      <= rd_idx;
            cur_link <= rd_link;
            if (rd_idx == list_tail) begin
              list_tail <= prev;
            end
            if (rd_idx == list_head) begin
              list_head <= rd_link;
              state     <= S_UNLINK_FREE;
            end else begin
              state <= S_UNLINK_PREV;
            end
          end else begin
            prev <= rd_idx;
            if (link_ok) begin
              steps <= steps + 1'b1;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_UNLINK_PREV: begin
          state <= S_UNLINK_FREE;
        end
        S_UNLINK_FREE: begin
          free_head <= cur;
          cnt       <= cnt - 1'b1;
          state     <= S_DONE;
        end
        S_DONE: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign cnt_w        = 32'(cnt);
  assign res_valid    = (state == S_DONE);
  assign res.element  = res_elem;
  assign res.prio     = res_prio;
  assign res.status   = res_status;
  assign res.is_empty = (cnt == '0);
  assign res.count    = cnt_w[llpq_pkg::COUNT_W-1:0];

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= NIL)
    else $error("entry count above capacity");

  a_rd_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.rd_en |-> (rd_addr < NIL))
    else $error("node read at null index");

  a_no_rw_overlap: assert property (@(posedge clk) disable iff (rst)
    cmd.rd_en |-> !(cmd.wr_node || cmd.wr_link))
    else $error("node read and write in the same cycle");

  a_empty_consistent: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> ((cnt == '0) == (list_head == NIL)))
    else $error("list head disagrees with entry count");

  a_pop_shrinks: assert property (@(posedge clk) disable iff (rst)
    (state == S_UNLINK_FREE) |=> (cnt == $past(cnt) - 1'b1))
    else $error("unlink did not decrement count");

endmodule

/* hw/rtl/linked_list_priority_queue.sv */
// top level of the linked list priority queue: relation register, sequencer, output stage, node store
//
//   channel  signals                                       direction
//   in       in_valid/in_ready, func, element, priority_req  input beat
//   out      out_valid/out_ready, element_out, priority_out,
//            status, is_empty, count                        output beat
//   cfg      cfg_we, cfg_data (rel_mode)                    register write
//
// push writes the new node and, when the list is not empty, links it behind the tail;
// peek walks the whole list, lookup walks it until a match, pop walks it once more up to
// the node found and unlinks it; a request answered without a walk goes to the result.
// the walk reads one node per cycle through the single read port of the node store.
// unused nodes are tracked by a fill mark, so reset needs no clearing pass.
// a new beat is taken while a result still sits in the output stage; a stalled
// output holds the sequencer only once its next result is ready.
module linked_list_priority_queue #(
  parameter int CAPACITY = llpq_pkg::CAPACITY_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          func,
  input  logic signed [31:0]  element,
  input  logic signed [31:0]  priority_req,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [31:0]  element_out,
  output logic signed [31:0]  priority_out,
  output logic [1:0]          status,
  output logic                is_empty,
  output logic [4:0]          count
);

  localparam int IW = $clog2(CAPACITY + 1);

  logic [1:0]           rel_mode;
  llpq_pkg::store_cmd_t cmd;
  logic [IW-1:0]        rd_addr;
  logic [IW-1:0]        wr_addr;
  llpq_pkg::word_t      wr_elem;
  llpq_pkg::word_t      wr_prio;
  logic [IW-1:0]        wr_link;
  logic [IW-1:0]        rd_idx;
  llpq_pkg::word_t      rd_elem;
  llpq_pkg::word_t      rd_prio;
  logic [IW-1:0]        rd_link;
  logic                 res_valid;
  logic                 res_ready;
  llpq_pkg::result_t    res;

  always_ff @(posedge clk) begin
    if (rst) begin
      rel_mode <= llpq_pkg::REL_LT;
    end else if (cfg_we) begin
      rel_mode <= cfg_data;
    end
  end

  llpq_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .rel_mode     (rel_mode),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .func         (func),
    .element      (element),
    .priority_req (priority_req),
    .cmd          (cmd),
    .rd_addr      (rd_addr),
    .wr_addr      (wr_addr),
    .wr_elem      (wr_elem),
    .wr_prio      (wr_prio),
    .wr_link      (wr_link),
    .rd_idx       (rd_idx),
    .rd_elem      (rd_elem),
    .rd_prio      (rd_prio),
    .rd_link      (rd_link),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .res          (res)
  );

  llpq_store #(
    .CAPACITY (CAPACITY)
  ) u_store (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .rd_addr (rd_addr),
    .wr_addr (wr_addr),
    .wr_elem (wr_elem),
    .wr_prio (wr_prio),
    .wr_link (wr_link),
    .rd_idx  (rd_idx),
    .rd_elem (rd_elem),
    .rd_prio (rd_prio),
    .rd_link (rd_link)
  );

  // output stage: refill when empty or draining this cycle
  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      element_out  <= res.element;
      priority_out <= res.prio;
      status       <= res.status;
      is_empty     <= res.is_empty;
      count        <= res.count;
    end
  end

endmodule
